// ===== hdl/lsb_multiplane_stego_engine_defines.svh =====
// assertion macros shared by the stego engine checker
// no dependencies; included by hdl/lmse_checker.sv
`ifndef LSB_MULTIPLANE_STEGO_ENGINE_DEFINES_SVH
`define LSB_MULTIPLANE_STEGO_ENGINE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LMSE_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define LMSE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also watches the reset itself
`define LMSE_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
    label: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/lmse_pkg.sv =====
// types, codes and cursor helpers for the multi-plane lsb stego engine
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package lmse_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int CHANNELS    = 3;
    localparam int BYTE_BITS   = 8;
    localparam int MAX_PLANES  = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_READ    = 3'd1;
    localparam logic [2:0] MODE_RESTART = 3'd2;
    localparam logic [2:0] MODE_EMBED   = 3'd3;
    localparam logic [2:0] MODE_EXTRACT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES = 2'd2;

    typedef struct packed {
        logic [2:0] plane;
        logic [1:0] ch;
        logic [6:0] row;
        logic [6:0] col;
    } cursor_t;

    typedef struct packed {
        cursor_t nxt;
        logic    wrap_end;
    } step_t;

    // one step of the cursor: column, row, channel, plane
    function automatic step_t cursor_step(cursor_t c, logic [7:0] w, logic [7:0] h,
                                          logic [3:0] p);
        step_t      s;
        logic [7:0] col_n;
        logic [7:0] row_n;
        logic [3:0] plane_n;
        s          = '0;
        s.nxt      = c;
        col_n      = {1'b0, c.col} + 8'd1;
        row_n      = {1'b0, c.row} + 8'd1;
        plane_n    = {1'b0, c.plane} + 4'd1;
        s.nxt.col  = col_n[6:0];
        if (col_n == w) begin
            s.nxt.col = '0;
            s.nxt.row = row_n[6:0];
            if (row_n == h) begin
                s.nxt.row = '0;
                s.nxt.ch  = c.ch + 2'd1;
                if (c.ch == 2'(CHANNELS - 1)) begin
                    s.nxt.ch    = '0;
                    s.nxt.plane = plane_n[2:0];
                    if (plane_n == p) begin
                        s.nxt.plane = '0;
                        s.wrap_end  = 1'b1;
                    end
                end
            end
        end
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(logic [6:0] row, logic [6:0] col,
                                                     logic [1:0] ch);
        return ADDR_W'({row, col}) * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lsb_multiplane_stego_engine.sv =====
// top level of the multi-plane lsb stego engine: frame memory, bit cursor, control
// depends on hdl/lmse_pkg.sv
// Frame memory of 128 x 128 x 3 eight-bit samples, one read and one write port.
// Items are taken one at a time; s_tready is high whenever no item is in work, also
// while a result beat still waits on m_tready. A restart or an unused mode goes
// straight to the hand-over, a load writes its sample to the memory first, and a
// read fetches the stored sample first. An embed or extract steps a copy of the
// cursor over the next positions to prove eight of them remain, then makes a
// read-modify-write pass through the memory at one bit per cycle (read of bit n+1
// beside the write of bit n; an extract only reads), then hands the result over.
// A byte skipped because the cursor is already spent or lies outside the image goes
// straight to the hand-over; one that the look-ahead finds short ends after the
// look-ahead. The hand-over waits while an earlier result beat is held by m_tready.
`timescale 1ns / 1ps
`default_nettype none

module lsb_multiplane_stego_engine
    import lmse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sample_row, sample_col, sample_channel, sample_value, message_byte
    input  wire logic [31:0]          s_tdata,
    // mode
    input  wire logic [2:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // result_value
    output logic [7:0]                m_tdata,
    // status
    output logic [0:0]                m_tuser
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_RUN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t      state_reg;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [3:0]  planes_reg;
    logic [7:0]  w_eff;
    logic [7:0]  h_eff;
    logic [3:0]  p_eff;

    cursor_t     cur_reg;
    cursor_t     sh_reg;
    logic        exhausted_reg;
    logic        fail_reg;
    logic [2:0]  chk_cnt_reg;
    logic [3:0]  bit_cnt_reg;
    logic [2:0]  mode_reg;
    logic [6:0]  row_reg;
    logic [6:0]  col_reg;
    logic [1:0]  ch_reg;
    logic [7:0]  value_reg;
    logic [7:0]  msg_reg;
    logic [7:0]  res_reg;
    logic        status_reg;
    logic [ADDR_W-1:0] prev_addr_reg;
    logic [2:0]  prev_plane_reg;

    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_user_reg;

    logic [7:0]  frame_mem [STORE_DEPTH];
    logic [7:0]  rd_data_reg;
    logic        mem_re;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]  mem_wdata;

    step_t       live_step;
    step_t       shadow_step;
    logic        cursor_ok;
    logic        item_in_store;
    logic [ADDR_W-1:0] item_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [7:0]  plane_mask;
    logic        take_item;

    logic [2:0]  in_mode;
    logic [6:0]  in_row;
    logic [6:0]  in_col;
    logic [1:0]  in_ch;
    logic [7:0]  in_value;
    logic [7:0]  in_msg;

    assign in_mode  = s_tuser;
    assign in_row   = s_tdata[6:0];
    assign in_col   = s_tdata[13:7];
    assign in_ch    = s_tdata[15:14];
    assign in_value = s_tdata[23:16];
    assign in_msg   = s_tdata[31:24];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign take_item = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // saturated geometry
    always_comb begin
        if (width_reg == 8'd0) begin
            w_eff = 8'd1;
        end else if (width_reg > 8'(MAX_WIDTH)) begin
            w_eff = 8'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == 8'd0) begin
            h_eff = 8'd1;
        end else if (height_reg > 8'(MAX_HEIGHT)) begin
            h_eff = 8'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if (planes_reg == 4'd0) begin
            p_eff = 4'd1;
        end else if (planes_reg > 4'(MAX_PLANES)) begin
            p_eff = 4'(MAX_PLANES);
        end else begin
            p_eff = planes_reg;
        end
    end

    assign live_step   = cursor_step(cur_reg, w_eff, h_eff, p_eff);
    assign shadow_step = cursor_step(sh_reg, w_eff, h_eff, p_eff);
    assign cursor_ok   = !exhausted_reg && ({1'b0, cur_reg.col} < w_eff)
                         && ({1'b0, cur_reg.row} < h_eff) && (cur_reg.ch < 2'(CHANNELS))
                         && ({1'b0, cur_reg.plane} < p_eff);
    assign item_in_store = (ch_reg < 2'(CHANNELS));
    assign item_addr     = store_addr(row_reg, col_reg, ch_reg);
    assign cur_addr      = store_addr(cur_reg.row, cur_reg.col, cur_reg.ch);
    assign plane_mask    = 8'd1 << prev_plane_reg;

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = cur_addr;
        mem_waddr = prev_addr_reg;
        mem_wdata = (rd_data_reg & ~plane_mask) | ({8{msg_reg[0]}} & plane_mask);
        case (state_reg)
            S_LOAD: begin
                mem_we    = item_in_store;
                mem_waddr = item_addr;
                mem_wdata = value_reg;
            end
            S_FETCH: begin
                mem_re    = item_in_store;
                mem_raddr = item_addr;
            end
            S_RUN: begin
                mem_re = (bit_cnt_reg != 4'(BYTE_BITS));
                mem_we = (bit_cnt_reg != 4'd0) && (mode_reg == MODE_EMBED);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= frame_mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'(MAX_WIDTH);
            height_reg <= 8'(MAX_HEIGHT);
            planes_reg <= 4'd3;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_PLANES: planes_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (take_item) begin
            mode_reg  <= in_mode;
            row_reg   <= in_row;
            col_reg   <= in_col;
            ch_reg    <= in_ch;
            value_reg <= in_value;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            exhausted_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take_item) begin
                        res_reg     <= '0;
                        status_reg  <= 1'b0;
                        msg_reg     <= in_msg;
                        sh_reg      <= cur_reg;
                        fail_reg    <= 1'b0;
                        chk_cnt_reg <= '0;
                        bit_cnt_reg <= '0;
                        case (in_mode)
                            MODE_LOAD:  state_reg <= S_LOAD;
                            MODE_READ:  state_reg <= S_FETCH;
                            MODE_RESTART: begin
                                cur_reg       <= '0;
                                exhausted_reg <= 1'b0;
                                state_reg     <= S_DONE;
                            end
                            MODE_EMBED, MODE_EXTRACT: begin
                                if (cursor_ok) begin
                                    state_reg <= S_CHECK;
                                end else begin
                                    exhausted_reg <= 1'b1;
                                    status_reg    <= 1'b1;
                                    state_reg     <= S_DONE;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_LOAD: begin
                    state_reg <= S_DONE;
                end
                S_FETCH: begin
                    state_reg <= S_READ;
                end
                S_READ: begin
                    res_reg   <= item_in_store ? rd_data_reg : 8'd0;
                    state_reg <= S_DONE;
                end
                S_CHECK: begin
                    // seven steps ahead must stay inside the carrier
                    sh_reg      <= shadow_step.nxt;
                    chk_cnt_reg <= chk_cnt_reg + 3'd1;
                    if (shadow_step.wrap_end) begin
                        fail_reg <= 1'b1;
                    end
                    if (chk_cnt_reg == 3'(BYTE_BITS - 2)) begin
                        if (fail_reg || shadow_step.wrap_end) begin
                            exhausted_reg <= 1'b1;
                            status_reg    <= 1'b1;
                            state_reg     <= S_DONE;
                        end else begin
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    bit_cnt_reg <= bit_cnt_reg + 4'd1;
                    if (bit_cnt_reg != 4'(BYTE_BITS)) begin
                        cur_reg        <= live_step.nxt;
                        prev_addr_reg  <= cur_addr;
                        prev_plane_reg <= cur_reg.plane;
                        if (live_step.wrap_end) begin
                            exhausted_reg <= 1'b1;
                        end
                    end else begin
                        state_reg <= S_DONE;
                    end
                    if (bit_cnt_reg != 4'd0) begin
                        msg_reg <= {1'b0, msg_reg[7:1]};
                        if (mode_reg == MODE_EXTRACT) begin
                            res_reg <= {rd_data_reg[prev_plane_reg], res_reg[7:1]};
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        m_user_reg  <= status_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmse_checker.sv =====
// port-level checker for the stego engine, bound to the top level
// depends on hdl/lsb_multiplane_stego_engine_defines.svh and hdl/lsb_multiplane_stego_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_multiplane_stego_engine_defines.svh"

module lmse_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [7:0]  cfg_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [0:0]  m_tuser
);

    `LMSE_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !aresetn, !m_tvalid, "result beat after reset")
    `LMSE_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
    `LMSE_ASSERT_NOW(a_skip_is_zero, m_tvalid && m_tuser[0], m_tdata == 8'd0,
        "skipped byte with nonzero data")
    `LMSE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input taken while an item is in work")
    `LMSE_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), !$past(s_tready),
        "result beat without an item in work")

endmodule

bind lsb_multiplane_stego_engine lmse_checker u_lmse_checker (.*);

`default_nettype wire
